// ----- rtl/gpgs_pkg.sv -----
package gpgs_pkg;

	// phase codes
	localparam logic [2:0] PH_ALIGN1   = 3'd0;
	localparam logic [2:0] PH_APPROACH = 3'd1;
	localparam logic [2:0] PH_ALIGN2   = 3'd2;
	localparam logic [2:0] PH_SURGE    = 3'd3;
	localparam logic [2:0] PH_DONE     = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_YAW_LIMIT   = 2'd0;
	localparam logic [1:0] REG_SURGE_SPEED = 2'd1;
	localparam logic [1:0] REG_DEPTH_SP    = 2'd2;

	// the divisor is never below 128, so the quotient of (mag << 13) stays below 2^22
	localparam int DIV_STEPS = 22;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [15:0] MIN_DIST       = 16'd128;
	localparam logic [15:0] CLOSE_DIST     = 16'd384;
	localparam logic signed [15:0] TH_ALIGN1 = 16'sd410;
	localparam logic signed [15:0] TH_ALIGN2 = 16'sd328;
	localparam logic [2:0] CONFIRM_FRAMES  = 3'd5;
	localparam logic [4:0] MISS_LIMIT      = 5'd30;
	localparam logic signed [16:0] PI_Q     = 17'sd25736;
	localparam logic signed [16:0] TWO_PI_Q = 17'sd51472;
	localparam logic [12:0] SIXTENTHS_Q    = 13'd4915;

	typedef logic [DIV_STEPS-1:0] quo_t;

endpackage

// ----- rtl/gpgs_div.sv -----
module gpgs_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [15:0]     mag,
	input  logic [15:0]     den,
	output logic            done,
	output gpgs_pkg::quo_t  quo
);
	import gpgs_pkg::*;

	logic [15:0]          rem_q;
	logic [15:0]          den_q;
	logic [DIV_STEPS-1:0] num_q;
	quo_t                 quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [16:0] shifted;
	logic [17:0] diff;
	logic        ge;

	always_comb begin
		shifted = {rem_q, num_q[DIV_STEPS-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		ge      = ~diff[17];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle; the top numerator bits
	// alone stay below the divisor, so they preload the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {9'd0, mag[15:9]};
			num_q <= {mag[8:0], 13'd0};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : shifted[15:0];
			num_q <= {num_q[DIV_STEPS-2:0], 1'b0};
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/gate_pass_guidance_sequencer.sv -----
// Gate-pass guidance sequencer.
// Input stream s_*: one word per camera frame or start command. s_tuser is op
// (0 start, 1 frame); s_tdata carries seen, obj_x, obj_dist, cur_yaw.
// Output stream m_*: exactly one command word per input word, carrying yaw,
// surge and depth commands, a command-valid flag, done and the phase.
// Configuration: cfg_we writes cfg_data to register cfg_idx (0 yaw_limit,
// 1 surge_speed, 2 depth_setpoint) in the same cycle; write only while idle.
// Flow: every word runs the serial divider for the normalized offset, one
// quotient bit per cycle. No new word is taken before the last one has left
// the finishing step for the output register; s_tready is high only while no
// word is in the divider or the finishing step.
// The command sits in an output register, so the next word is accepted while
// it waits; if m_tready stays low, the following word holds in the finishing
// step until the register frees.
// Reset clears the phase sequence, the filter and the output valid, and
// loads the registers with yaw_limit 4096, surge_speed 4096, depth 256.
module gate_pass_guidance_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // seen[0], obj_x[16:1], obj_dist[32:17], cur_yaw[48:33]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // yaw_cmd[15:0], surge_cmd[30:16], depth_cmd[46:31],
	                               // cmd_valid[47], done_res[48], phase_now[51:49]
);
	import gpgs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;

	logic [14:0] yaw_limit_q;
	logic [14:0] surge_speed_q;
	logic [15:0] depth_sp_q;

	logic [2:0]         phase_q;
	logic [2:0]         align_cnt_q;
	logic [4:0]         lost_cnt_q;
	logic signed [15:0] held_q;
	logic signed [15:0] smooth_q;

	logic               op_q;
	logic               seen_q;
	logic signed [15:0] x_q;
	logic [15:0]        dist_q;
	logic signed [15:0] yaw_q;

	logic        accept;
	logic        div_done;
	quo_t        quo;
	logic [15:0] in_mag;
	logic [15:0] in_den;
	logic        fin_go;

	logic signed [15:0] in_x;
	logic [15:0]        in_dist;

	assign accept   = s_tvalid & s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_x     = s_tdata[16:1];
	assign in_dist  = s_tdata[32:17];
	assign in_mag   = in_x[15] ? 16'(-in_x) : in_x;
	assign in_den   = (in_dist < MIN_DIST) ? MIN_DIST : in_dist;
	assign fin_go   = (state_q == ST_FIN) && (!m_tvalid || m_tready);

	gpgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (in_mag),
		.den    (in_den),
		.done   (div_done),
		.quo    (quo)
	);

	// ---- finishing step: norm, filter, phase logic ----
	logic signed [15:0] norm;
	logic signed [15:0] err;
	logic signed [17:0] ema_sum;
	logic signed [15:0] ema_v;
	logic signed [15:0] lim;
	logic signed [15:0] ycmd_ema;
	logic signed [15:0] th;
	logic               centered;
	logic [27:0]        speed_prod;
	logic signed [16:0] yaw_diff;
	logic signed [16:0] yaw_wrap;

	logic [2:0]         phase_d;
	logic [2:0]         align_cnt_d;
	logic [4:0]         lost_cnt_d;
	logic signed [15:0] held_d;
	logic signed [15:0] smooth_d;
	logic [15:0]        ycmd;
	logic [14:0]        scmd;
	logic               valid;
	logic               done;

	always_comb begin
		if (x_q[15])
			norm = (quo > quo_t'(32768)) ? -16'sd32768 : 16'(-quo[15:0]);
		else
			norm = (quo > quo_t'(32767)) ? 16'sd32767 : quo[15:0];
		err = (norm == -16'sd32768) ? 16'sd32767 : -norm;

		ema_sum = {{2{err[15]}}, err} + {{2{smooth_q[15]}}, smooth_q}
			+ {smooth_q[15], smooth_q, 1'b0};
		ema_v = (smooth_q == 16'sd0) ? err : ema_sum[17:2];

		lim = {1'b0, yaw_limit_q};
		if (ema_v > lim)
			ycmd_ema = lim;
		else if (ema_v < -lim)
			ycmd_ema = -lim;
		else
			ycmd_ema = ema_v;

		th       = (phase_q == PH_ALIGN1) ? TH_ALIGN1 : TH_ALIGN2;
		centered = (norm < th) && (norm > -th);

		speed_prod = surge_speed_q * SIXTENTHS_Q;

		yaw_diff = {held_q[15], held_q} - {yaw_q[15], yaw_q};
		if (yaw_diff > PI_Q)
			yaw_wrap = yaw_diff - TWO_PI_Q;
		else if (yaw_diff < -PI_Q)
			yaw_wrap = yaw_diff + TWO_PI_Q;
		else
			yaw_wrap = yaw_diff;
	end

	always_comb begin
		phase_d     = phase_q;
		align_cnt_d = align_cnt_q;
		lost_cnt_d  = lost_cnt_q;
		held_d      = held_q;
		smooth_d    = smooth_q;
		ycmd        = '0;
		scmd        = '0;
		valid       = 1'b0;
		done        = 1'b0;

		if (!op_q) begin
			phase_d     = PH_ALIGN1;
			align_cnt_d = '0;
			lost_cnt_d  = '0;
			held_d      = '0;
			smooth_d    = '0;
		end else begin
			unique case (phase_q) inside
				PH_ALIGN1, PH_ALIGN2: begin
					if (!seen_q) begin
						valid = 1'b1;
					end else if (centered && (align_cnt_q + 3'd1 >= CONFIRM_FRAMES)) begin
						align_cnt_d = '0;
						if (phase_q == PH_ALIGN1) begin
							phase_d  = PH_APPROACH;
							smooth_d = '0;
						end else begin
							held_d     = yaw_q;
							phase_d    = PH_SURGE;
							lost_cnt_d = '0;
							valid      = 1'b1;
							scmd       = surge_speed_q;
						end
					end else begin
						align_cnt_d = centered ? align_cnt_q + 3'd1 : 3'd0;
						smooth_d    = ema_v;
						ycmd        = ycmd_ema;
						valid       = 1'b1;
					end
				end
				PH_APPROACH: begin
					valid = 1'b1;
					if (!seen_q) begin
						scmd = {1'b0, surge_speed_q[14:1]};
					end else if (dist_q <= CLOSE_DIST) begin
						phase_d     = PH_ALIGN2;
						align_cnt_d = '0;
						smooth_d    = '0;
					end else begin
						smooth_d = ema_v;
						ycmd     = ycmd_ema;
						scmd     = speed_prod[27:13];
					end
				end
				PH_SURGE: begin
					valid = 1'b1;
					if (!seen_q) begin
						if (lost_cnt_q + 5'd1 >= MISS_LIMIT) begin
							phase_d    = PH_DONE;
							lost_cnt_d = '0;
							done       = 1'b1;
						end else begin
							lost_cnt_d = lost_cnt_q + 5'd1;
						end
					end else begin
						lost_cnt_d = '0;
					end
					if (!done) begin
						ycmd = yaw_wrap[15:0];
						scmd = surge_speed_q;
					end
				end
				default: begin
					phase_d = PH_DONE;
					done    = 1'b1;
				end
			endcase
		end
	end

	// ---- control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_FIN;
				ST_FIN:  if (fin_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_limit_q   <= 15'd4096;
			surge_speed_q <= 15'd4096;
			depth_sp_q    <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_YAW_LIMIT:   yaw_limit_q   <= cfg_data[14:0];
				REG_SURGE_SPEED: surge_speed_q <= cfg_data[14:0];
				REG_DEPTH_SP:    depth_sp_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ALIGN1;
			align_cnt_q <= '0;
			lost_cnt_q  <= '0;
			held_q      <= '0;
			smooth_q    <= '0;
		end else if (fin_go) begin
			phase_q     <= phase_d;
			align_cnt_q <= align_cnt_d;
			lost_cnt_q  <= lost_cnt_d;
			held_q      <= held_d;
			smooth_q    <= smooth_d;
		end
	end

	// hold the input word for the finishing step
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			seen_q <= s_tdata[0];
			x_q    <= in_x;
			dist_q <= in_dist;
			yaw_q  <= s_tdata[48:33];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (fin_go)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go)
			m_tdata <= {4'd0, phase_d, done, valid, (valid ? depth_sp_q : 16'd0), scmd, ycmd};
	end

	// ---- checks ----
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_DONE)
		else $error("phase register out of range");

	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[48] |-> m_tdata[51:49] == PH_DONE)
		else $error("done reported outside the done phase");

	a_div_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready stayed high after a word was taken");

endmodule
